/* src/mvpm_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// mvpm_pkg - shared definitions for the multi-voice PCM mixer
// Command codes, channel field widths, default sizes and the result word
// that passes from the mixing sequencer to the output stage.
// ============================================================================
package mvpm_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int DEF_MAX_VOICES      = 16;
  localparam int DEF_NUM_SOUND_SLOTS = 8;
  localparam int DEF_SOUND_BYTES     = 16384;
  localparam int DEF_MAX_FRAGMENT    = 512;

  // Configuration register.
  localparam int FRAG_W     = 10;
  localparam int FRAG_RESET = 128;

  // Channel field widths.
  localparam int CMD_W      = 3;
  localparam int SND_IN_W   = 3;
  localparam int BOFF_W     = 14;
  localparam int BYTE_W     = 8;
  localparam int SLEN_W     = 15;
  localparam int VOICES_W   = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  // Mix accumulator, wide enough for the largest voice count allowed.
  localparam int SUM_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LENGTH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 3'd4;

  // Raw unsigned bytes are stored with the top bit flipped, as signed samples.
  localparam logic [BYTE_W-1:0] SIGN_FLIP = 8'h80;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [VOICES_W-1:0]     voices;
  } mvpm_result_t;

endpackage

/* src/mvpm_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// mvpm_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module mvpm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* src/mvpm_out_stage.sv */
`timescale 1ns / 1ps
// ============================================================================
// mvpm_out_stage - clamp and output register
// Maps the signed voice sum to an unsigned PCM byte and holds the result
// word until the downstream side takes it.
// ============================================================================
module mvpm_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mvpm_pkg::mvpm_result_t              res,
  input  logic                                res_load,
  output logic                                res_room,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: mixed_sample (8), active_voices (5), zero fill.
  output logic [mvpm_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import mvpm_pkg::*;

  localparam logic signed [SUM_W-1:0] PCM_HI = 16'sd255;
  localparam logic signed [SUM_W-1:0] PCM_LO = -16'sd256;
  localparam logic signed [SUM_W-1:0] BIAS   = 16'sd256;

  logic                    valid_r, valid_nxt;
  logic [BYTE_W-1:0]       pcm_r, pcm_nxt;
  logic [VOICES_W-1:0]     voices_r, voices_nxt;
  logic signed [SUM_W-1:0] biased;
  logic [BYTE_W-1:0]       pcm;

  always_comb begin
    biased = res.sum + BIAS;
    if (res.sum > PCM_HI) begin
      pcm = {BYTE_W{1'b1}};
    end else if (res.sum < PCM_LO) begin
      pcm = '0;
    end else begin
      pcm = biased[BYTE_W:1];
    end
  end

  assign res_room = !valid_r || out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    pcm_nxt    = pcm_r;
    voices_nxt = voices_r;
    if (res_load) begin
      valid_nxt  = 1'b1;
      pcm_nxt    = pcm;
      voices_nxt = res.voices;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    pcm_r    <= pcm_nxt;
    voices_r <= voices_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VOICES_W - BYTE_W){1'b0}}, voices_r, pcm_r};

endmodule

/* src/multi_voice_pcm_mixer.sv */
`timescale 1ns / 1ps
// ============================================================================
// multi_voice_pcm_mixer - eight-bit PCM mixer with a list of playing voices
// Load, length, start and stop commands are handled directly in the idle state. An
// output sample command holds in_tready low from accept until its result word
// is loaded into the output register, including any wait for out_tready to
// free that register: the voice list memory streams one voice per cycle
// through a three-stage read pipeline into the sample memory and accumulator.
// Reset (synchronous, active low) clears lengths, loaded flags, the voice
// list, the fragment position and sets frag_size to 128; sample memory and
// voice entries are not cleared and need no clearing pass.
// ============================================================================
module multi_voice_pcm_mixer #(
  parameter int MAX_VOICES      = mvpm_pkg::DEF_MAX_VOICES,
  parameter int NUM_SOUND_SLOTS = mvpm_pkg::DEF_NUM_SOUND_SLOTS,
  parameter int SOUND_BYTES     = mvpm_pkg::DEF_SOUND_BYTES,
  parameter int MAX_FRAGMENT    = mvpm_pkg::DEF_MAX_FRAGMENT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // frag_size register.
  input  logic                              cfg_we,
  input  logic [mvpm_pkg::FRAG_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0 up: sound_index (3), byte_offset (14), byte_value (8),
  // sound_length (15).
  input  logic [mvpm_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields from bit 0 up: command (3).
  input  logic [mvpm_pkg::CMD_W-1:0]        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0 up: mixed_sample (8), active_voices (5), zero fill.
  output logic [mvpm_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import mvpm_pkg::*;

  // Derived widths.
  localparam int SND_W    = (NUM_SOUND_SLOTS > 1) ? $clog2(NUM_SOUND_SLOTS) : 1;
  localparam int VI_W     = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W    = $clog2(MAX_VOICES + 1);
  localparam int SL_W     = CNT_W + 1;
  localparam int LEN_W    = $clog2(SOUND_BYTES + 1);
  // A voice is retired one fragment after passing its length, so its offset
  // never exceeds the longest sound plus one fragment.
  localparam int OFF_W    = $clog2(SOUND_BYTES + MAX_FRAGMENT + 1);
  localparam int IDX_W    = OFF_W + 1;
  localparam int CTR_W    = $clog2(MAX_FRAGMENT);
  localparam int FS_W     = $clog2(MAX_FRAGMENT + 1);
  localparam int SA_DEPTH = NUM_SOUND_SLOTS * SOUND_BYTES;
  localparam int SA_W     = $clog2(SA_DEPTH);
  localparam int VD_W     = SND_W + OFF_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // Input fields.
  logic [CMD_W-1:0]    in_cmd;
  logic [SND_IN_W-1:0] in_snd;
  logic [BOFF_W-1:0]   in_boff;
  logic [BYTE_W-1:0]   in_byte;
  logic [SLEN_W-1:0]   in_slen;

  assign in_cmd  = in_tuser;
  assign in_snd  = in_tdata[2:0];
  assign in_boff = in_tdata[16:3];
  assign in_byte = in_tdata[24:17];
  assign in_slen = in_tdata[39:25];

  // Control and table state.
  logic [1:0]        state_r, state_nxt;
  logic [FRAG_W-1:0] frag_r, frag_nxt;
  logic [LEN_W-1:0]  len_r [NUM_SOUND_SLOTS];
  logic [LEN_W-1:0]  len_nxt [NUM_SOUND_SLOTS];
  logic [NUM_SOUND_SLOTS-1:0] loaded_r, loaded_nxt;
  logic [VI_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CTR_W-1:0]  ctr_r, ctr_nxt;
  // Running fragment position; a voice stores the position at which it joined
  // and its offset is the difference, so no pass is needed to advance voices.
  logic [OFF_W-1:0]  pos_r, pos_nxt;

  // Mix pass bookkeeping.
  logic [CNT_W-1:0]  rd_i_r, rd_i_nxt;
  logic [CNT_W-1:0]  wr_w_r, wr_w_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              retire_r, retire_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              s3_v_r, s3_v_nxt;
  logic [SND_W-1:0]  s2_snd_r, s2_snd_nxt;
  logic [OFF_W-1:0]  s2_join_r, s2_join_nxt;
  logic [OFF_W-1:0]  s2_off_r, s2_off_nxt;
  logic [LEN_W-1:0]  s2_len_r, s2_len_nxt;
  logic              s2_keep_r, s2_keep_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;

  // Memory ports.
  logic              vram_we;
  logic [VI_W-1:0]   vram_waddr, vram_raddr;
  logic [VD_W-1:0]   vram_wdata, vram_rdata;
  logic              sram_we;
  logic [SA_W-1:0]   sram_waddr, sram_raddr;
  logic [BYTE_W-1:0] sram_wdata, sram_rdata;

  // Helpers.
  logic              in_fire;
  logic              snd_ok, off_ok, start_ok, issue;
  logic [SND_W-1:0]  snd_idx;
  logic [LEN_W-1:0]  len_sat;
  logic [FS_W-1:0]   fs, ctr_p1;
  logic [SND_W-1:0]  v_snd;
  logic [OFF_W-1:0]  v_join, v_off;
  logic [LEN_W-1:0]  v_len;
  logic [IDX_W-1:0]  s2_idx;
  logic              s2_hit;
  mvpm_result_t      res;
  logic              res_load, res_room;

  // Position in the circular voice list, base plus step, wrapped.
  function automatic logic [VI_W-1:0] slot_of(input logic [VI_W-1:0] base,
                                              input logic [CNT_W-1:0] step);
    logic [SL_W-1:0] s;
    s = SL_W'(base) + SL_W'(step);
    if (s >= SL_W'(MAX_VOICES)) begin
      s = s - SL_W'(MAX_VOICES);
    end
    return VI_W'(s);
  endfunction

  // Effective fragment size: zero acts as one, large values saturate.
  always_comb begin
    if (frag_r == '0) begin
      fs = FS_W'(1);
    end else if (32'(frag_r) > MAX_FRAGMENT) begin
      fs = FS_W'(MAX_FRAGMENT);
    end else begin
      fs = FS_W'(frag_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign snd_ok   = 32'(in_snd) < NUM_SOUND_SLOTS;
  assign off_ok   = 32'(in_boff) < SOUND_BYTES;
  assign snd_idx  = SND_W'(in_snd);
  assign start_ok = snd_ok && loaded_r[snd_idx] && (32'(count_r) < MAX_VOICES);
  assign len_sat  = (32'(in_slen) > SOUND_BYTES) ? LEN_W'(SOUND_BYTES) : LEN_W'(in_slen);

  // Sample memory writes come straight from load commands.
  assign sram_we    = in_fire && (in_cmd == CMD_LOAD) && snd_ok && off_ok;
  assign sram_waddr = SA_W'(32'(in_snd) * SOUND_BYTES + 32'(in_boff));
  assign sram_wdata = in_byte ^ SIGN_FLIP;

  // Stage one: a voice entry has come back from the voice list. Work out its
  // offset and whether it survives the retire check at a fragment start.
  assign v_snd  = vram_rdata[VD_W-1:OFF_W];
  assign v_join = vram_rdata[OFF_W-1:0];
  assign v_off  = pos_r - v_join;
  assign v_len  = len_r[v_snd];

  // Stage two: byte index within the sound and sample memory address. Bytes
  // at or past the sound's length count as zero and are not accumulated.
  assign s2_idx     = IDX_W'(s2_off_r) + IDX_W'(ctr_r);
  assign s2_hit     = s2_idx < IDX_W'(s2_len_r);
  assign sram_raddr = SA_W'(32'(s2_snd_r) * SOUND_BYTES + 32'(s2_idx));

  assign issue      = (state_r == ST_MIX) && (rd_i_r != n_r);
  assign vram_raddr = slot_of(head_r, rd_i_r);
  assign ctr_p1     = FS_W'(ctr_r) + FS_W'(1);

  always_comb begin
    state_nxt   = state_r;
    frag_nxt    = cfg_we ? cfg_wdata : frag_r;
    len_nxt     = len_r;
    loaded_nxt  = loaded_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    ctr_nxt     = ctr_r;
    pos_nxt     = pos_r;
    rd_i_nxt    = rd_i_r;
    wr_w_nxt    = wr_w_r;
    n_nxt       = n_r;
    retire_nxt  = retire_r;
    s1_v_nxt    = 1'b0;
    s2_v_nxt    = 1'b0;
    s3_v_nxt    = 1'b0;
    s2_snd_nxt  = v_snd;
    s2_join_nxt = v_join;
    s2_off_nxt  = v_off;
    s2_len_nxt  = v_len;
    s2_keep_nxt = !(retire_r && (v_off > OFF_W'(v_len)));
    sum_nxt     = sum_r;
    vram_we     = 1'b0;
    vram_waddr  = slot_of(head_r, wr_w_r);
    vram_wdata  = {s2_snd_r, s2_join_r};
    res_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_LOAD: begin
              // Handled by the sample memory write port.
            end
            CMD_LENGTH: begin
              if (snd_ok) begin
                len_nxt[snd_idx]    = len_sat;
                loaded_nxt[snd_idx] = 1'b1;
              end
            end
            CMD_START: begin
              // New voice goes to the tail, joining at the current position.
              if (start_ok) begin
                vram_we    = 1'b1;
                vram_waddr = slot_of(head_r, count_r);
                vram_wdata = {snd_idx, pos_r};
                count_nxt  = count_r + CNT_W'(1);
              end
            end
            CMD_STOP: begin
              // Only the first voice goes: the head moves on.
              if (count_r != '0) begin
                head_nxt  = slot_of(head_r, CNT_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_SAMPLE: begin
              state_nxt  = ST_MIX;
              rd_i_nxt   = '0;
              wr_w_nxt   = '0;
              n_nxt      = count_r;
              sum_nxt    = '0;
              retire_nxt = (ctr_r == '0);
            end
            default: begin
            end
          endcase
        end
      end

      ST_MIX: begin
        if (issue) begin
          s1_v_nxt = 1'b1;
          rd_i_nxt = rd_i_r + CNT_W'(1);
        end
        s2_v_nxt = s1_v_r;
        // Survivors are written back packed toward the head. The write slot
        // never passes the read slot, so no entry is overwritten unread.
        if (s2_v_r && s2_keep_r) begin
          vram_we  = 1'b1;
          wr_w_nxt = wr_w_r + CNT_W'(1);
        end
        s3_v_nxt = s2_v_r && s2_keep_r && s2_hit;
        if (s3_v_r) begin
          sum_nxt = sum_r + {{(SUM_W - BYTE_W){sram_rdata[BYTE_W-1]}}, sram_rdata};
        end
        if (!issue && !s1_v_r && !s2_v_r && !s3_v_r) begin
          state_nxt = ST_OUT;
          count_nxt = wr_w_r;
          if (ctr_p1 >= fs) begin
            ctr_nxt = '0;
            pos_nxt = pos_r + OFF_W'(fs);
          end else begin
            ctr_nxt = CTR_W'(ctr_p1);
          end
        end
      end

      ST_OUT: begin
        if (res_room) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      frag_r   <= FRAG_W'(FRAG_RESET);
      for (int i = 0; i < NUM_SOUND_SLOTS; i++) begin
        len_r[i] <= '0;
      end
      loaded_r <= '0;
      head_r   <= '0;
      count_r  <= '0;
      ctr_r    <= '0;
      pos_r    <= '0;
      rd_i_r   <= '0;
      wr_w_r   <= '0;
      n_r      <= '0;
      retire_r <= 1'b0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      frag_r   <= frag_nxt;
      len_r    <= len_nxt;
      loaded_r <= loaded_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      ctr_r    <= ctr_nxt;
      pos_r    <= pos_nxt;
      rd_i_r   <= rd_i_nxt;
      wr_w_r   <= wr_w_nxt;
      n_r      <= n_nxt;
      retire_r <= retire_nxt;
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      s3_v_r   <= s3_v_nxt;
    end
    s2_snd_r  <= s2_snd_nxt;
    s2_join_r <= s2_join_nxt;
    s2_off_r  <= s2_off_nxt;
    s2_len_r  <= s2_len_nxt;
    s2_keep_r <= s2_keep_nxt;
    sum_r     <= sum_nxt;
  end

  // Voice list: sound slot and join position per entry, circular order.
  mvpm_ram #(
    .WIDTH (VD_W),
    .DEPTH (MAX_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  // Sample store: all sounds back to back, one signed byte per entry.
  mvpm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SA_DEPTH)
  ) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (sram_waddr),
    .wdata (sram_wdata),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  assign res.sum    = sum_r;
  assign res.voices = VOICES_W'(count_r);

  mvpm_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .res_load   (res_load),
    .res_room   (res_room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
